// ----- hw/rtl/cgff_pkg.sv -----
// Shared types, constants and helpers for the cell gradient and face flux block.
package cgff_pkg;

    localparam int SET_COUNT_DEF = 8;
    localparam int FACE_COUNT    = 6;
    localparam int AXES          = 3;
    localparam int MATRIX_WORDS  = AXES * AXES;
    localparam int SET_WORDS     = MATRIX_WORDS + AXES * FACE_COUNT;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_CELL = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_DIFF  = 2'd0,
        KIND_NODAL = 2'd1,
        KIND_FACE  = 2'd2,
        KIND_DIV   = 2'd3
    } t_kind;

    typedef struct packed {
        t_op                operation;
        logic [2:0]         set_index;
        logic [4:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] node_value;
        logic signed [31:0] face_0;
        logic signed [31:0] face_1;
        logic signed [31:0] face_2;
        logic signed [31:0] face_3;
        logic signed [31:0] face_4;
        logic signed [31:0] face_5;
    } t_in_word;

    typedef struct packed {
        t_kind              result_kind;
        logic [2:0]         face_number;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
        logic               last_result;
    } t_out_word;

    // classified command between front and back
    typedef struct packed {
        logic     set_ok;
        t_in_word word;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_RD,
        ST_MUL,
        ST_ACC,
        ST_EMIT_G,
        ST_EMIT_F,
        ST_EMIT_DIV
    } t_state;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -48'sh0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/cell_gradient_and_face_flux.sv -----
// Top level of the cell gradient and face flux block.
// Input channel: i_in_valid / o_in_stall carry one word per handshake. A load
// word (operation 0) writes one Q8.24 coefficient into set set_index at
// coef_index and gives no result. A cell word (operation 1) gives nine
// output words in order: differences, nodal gradient, face gradients 0..5,
// divergence (last_result set).
// Output channel: o_out_valid / i_out_stall; o_out_word is held while stalled.
// The back end has one multiplier used by 81 products per cell, each in the
// steps store read, multiply, round and accumulate. The back end finishes
// one cell before it takes the next word, and while idle it takes load
// words one per cycle. A two-word queue lets the front take words while a
// cell runs.
// Reset (synchronous, active low) empties the queue and output register; the
// coefficient store holds unknown values until written. A stalled output
// holds the sequencer, and the input stalls once the queue is full.
module cell_gradient_and_face_flux #(
    parameter int SET_COUNT = cgff_pkg::SET_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cgff_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cgff_pkg::t_out_word o_out_word
);
    import cgff_pkg::*;

    logic push, full, pop, q_valid;
    t_cmd front_cmd, q_cmd;

    cgff_front #(.SET_COUNT(SET_COUNT)) u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_push     (push),
        .o_cmd      (front_cmd),
        .i_full     (full)
    );

    cgff_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    cgff_back #(.SET_COUNT(SET_COUNT)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

// ----- hw/rtl/cgff_front.sv -----
// Front end: accepts input words, drops loads that address nothing, tags set validity.
module cgff_front #(
    parameter int SET_COUNT = cgff_pkg::SET_COUNT_DEF
) (
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  cgff_pkg::t_in_word i_in_word,
    output logic              o_push,
    output cgff_pkg::t_cmd    o_cmd,
    input  logic              i_full
);
    import cgff_pkg::*;

    logic set_ok;
    logic idx_ok;

    // classify the word
    always_comb begin
        set_ok = ({29'd0, i_in_word.set_index} < 32'(SET_COUNT));
        idx_ok = ({27'd0, i_in_word.coef_index} < 32'(SET_WORDS));
        o_cmd.set_ok = set_ok;
        o_cmd.word   = i_in_word;
    end

    assign o_in_stall = i_full;
    // a load outside the store is taken and dropped
    assign o_push = i_in_valid && !i_full &&
                    ((i_in_word.operation == OP_CELL) || (set_ok && idx_ok));

endmodule

// ----- hw/rtl/cgff_queue.sv -----
// Two-entry command queue between front and back.
module cgff_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cgff_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output cgff_pkg::t_cmd o_cmd
);
    import cgff_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- hw/rtl/cgff_back.sv -----
// Back end: coefficient store, shared multiplier sequencer and output register.
module cgff_back #(
    parameter int SET_COUNT = cgff_pkg::SET_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  cgff_pkg::t_cmd      i_q_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cgff_pkg::t_out_word o_out_word
);
    import cgff_pkg::*;

    localparam int DEPTH = SET_COUNT * SET_WORDS;
    localparam int AW    = $clog2(DEPTH);

    logic signed [31:0] r_mem [DEPTH];

    t_state             r_state, n_state;
    t_in_word           r_item;
    logic               r_zero;
    logic               r_phase;          // 0 nodal gradient, 1 faces
    logic [1:0]         r_k;
    logic [1:0]         r_t;
    logic [2:0]         r_fc;
    logic signed [31:0] r_coef;
    logic signed [64:0] r_prod;
    logic signed [47:0] r_acc;
    logic signed [47:0] r_dacc;
    logic signed [31:0] r_d  [AXES];
    logic signed [31:0] r_g  [AXES];
    logic signed [31:0] r_fg [AXES];
    logic signed [32:0] r_nd;
    logic               r_out_valid;
    t_out_word          r_out;

    logic               out_free;
    logic               emit;
    logic               pop;
    t_out_word          emit_word;
    logic signed [31:0] face [FACE_COUNT];
    logic signed [31:0] d_c  [AXES];
    logic [1:0]         l0, l1, l2;
    logic [4:0]         local_idx;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic signed [32:0] operand;
    logic signed [64:0] rnd23, rnd24;
    logic signed [47:0] term;
    logic signed [47:0] acc_sum;
    logic [2:0]         nd_fc;
    logic signed [32:0] nd_sat;
    logic signed [32:0] nd_c;

    assign out_free = !r_out_valid || !i_out_stall;

    // unpack faces and form opposite-face differences
    always_comb begin
        face[0] = r_item.face_0;
        face[1] = r_item.face_1;
        face[2] = r_item.face_2;
        face[3] = r_item.face_3;
        face[4] = r_item.face_4;
        face[5] = r_item.face_5;
        for (int k = 0; k < AXES; k++) begin
            d_c[k] = sat32(48'(face[2*k+1]) - 48'(face[2*k]));
        end
    end

    // axis rotation for the current face
    always_comb begin
        l0 = r_fc[2:1];
        l1 = (l0 == 2'd2) ? 2'd0 : l0 + 2'd1;
        l2 = (l0 == 2'd0) ? 2'd2 : l0 - 2'd1;
    end

    // coefficient address and operand for the current term
    always_comb begin
        if (!r_phase) begin
            local_idx = 5'(r_k * 3) + 5'(r_t);
            operand   = 33'(r_d[r_t]);
        end else begin
            case (r_t)
                2'd0: begin
                    local_idx = 5'(r_k * 3) + 5'(l0);
                    operand   = r_nd;
                end
                2'd1: begin
                    local_idx = 5'(r_k * 3) + 5'(l1);
                    operand   = 33'(r_d[l1]);
                end
                2'd2: begin
                    local_idx = 5'(r_k * 3) + 5'(l2);
                    operand   = 33'(r_d[l2]);
                end
                default: begin
                    local_idx = 5'(MATRIX_WORDS) + 5'(r_fc * 3) + 5'(r_k);
                    operand   = 33'(r_fg[r_k]);
                end
            endcase
        end
        rd_addr = AW'(int'(r_item.set_index) * SET_WORDS + int'(local_idx));
        wr_addr = AW'(int'(i_q_cmd.word.set_index) * SET_WORDS
                      + int'(i_q_cmd.word.coef_index));
    end

    // rounding of the registered product
    always_comb begin
        rnd24 = (r_prod + 65'sd8388608) >>> 24;
        rnd23 = (r_prod + 65'sd4194304) >>> 23;
        term  = (r_phase && r_t == 2'd0) ? rnd23[47:0] : rnd24[47:0];
        acc_sum = r_acc + term;
    end

    // node minus face for the next face, negated for odd faces
    always_comb begin
        nd_fc  = (r_state == ST_EMIT_G) ? 3'd0 : r_fc + 3'd1;
        nd_sat = 33'(sat32(48'(r_item.node_value) - 48'(face[nd_fc])));
        nd_c   = nd_fc[0] ? -nd_sat : nd_sat;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && i_q_cmd.word.operation == OP_CELL) begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF:   if (out_free) n_state = ST_RD;
            ST_RD:     n_state = ST_MUL;
            ST_MUL:    n_state = ST_ACC;
            ST_ACC: begin
                if (!r_phase) begin
                    n_state = (r_t == 2'd2 && r_k == 2'd2) ? ST_EMIT_G : ST_RD;
                end else begin
                    n_state = (r_t == 2'd3 && r_k == 2'd2) ? ST_EMIT_F : ST_RD;
                end
            end
            ST_EMIT_G: if (out_free) n_state = ST_RD;
            ST_EMIT_F: begin
                if (out_free) n_state = (r_fc == 3'd5) ? ST_EMIT_DIV : ST_RD;
            end
            ST_EMIT_DIV: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        pop       = 1'b0;
        emit      = 1'b0;
        emit_word = '0;
        case (r_state)
            ST_IDLE: pop = i_q_valid;
            ST_DIFF: begin
                emit                  = out_free;
                emit_word.result_kind = KIND_DIFF;
                emit_word.value_x     = d_c[0];
                emit_word.value_y     = d_c[1];
                emit_word.value_z     = d_c[2];
            end
            ST_EMIT_G: begin
                emit                  = out_free;
                emit_word.result_kind = KIND_NODAL;
                emit_word.value_x     = r_g[0];
                emit_word.value_y     = r_g[1];
                emit_word.value_z     = r_g[2];
            end
            ST_EMIT_F: begin
                emit                  = out_free;
                emit_word.result_kind = KIND_FACE;
                emit_word.face_number = r_fc;
                emit_word.value_x     = r_fg[0];
                emit_word.value_y     = r_fg[1];
                emit_word.value_z     = r_fg[2];
            end
            ST_EMIT_DIV: begin
                emit                  = out_free;
                emit_word.result_kind = KIND_DIV;
                emit_word.value_x     = sat32(r_dacc);
                emit_word.last_result = 1'b1;
            end
            default: begin
                pop  = 1'b0;
                emit = 1'b0;
            end
        endcase
    end

    assign o_pop = pop;

    // coefficient store
    always_ff @(posedge i_clk) begin
        if (pop && i_q_cmd.word.operation == OP_LOAD) begin
            r_mem[wr_addr] <= i_q_cmd.word.coef_value;
        end
        if (r_state == ST_RD) begin
            r_coef <= r_mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= emit_word;
        end
        case (r_state)
            ST_IDLE: begin
                if (pop) begin
                    r_item <= i_q_cmd.word;
                    r_zero <= !i_q_cmd.set_ok;
                end
            end
            ST_DIFF: begin
                for (int k = 0; k < AXES; k++) begin
                    r_d[k] <= d_c[k];
                end
                r_phase <= 1'b0;
                r_k     <= 2'd0;
                r_t     <= 2'd0;
                r_fc    <= 3'd0;
                r_acc   <= '0;
                r_dacc  <= '0;
            end
            ST_MUL: begin
                r_prod <= r_zero ? 65'sd0 : 65'(r_coef) * 65'(operand);
            end
            ST_ACC: begin
                if (!r_phase) begin
                    if (r_t == 2'd2) begin
                        r_g[r_k] <= sat32(acc_sum);
                        r_acc    <= '0;
                        r_t      <= 2'd0;
                        r_k      <= r_k + 2'd1;
                    end else begin
                        r_acc <= acc_sum;
                        r_t   <= r_t + 2'd1;
                    end
                end else if (r_t == 2'd3) begin
                    r_dacc <= r_dacc + term;
                    r_t    <= 2'd0;
                    r_k    <= r_k + 2'd1;
                end else if (r_t == 2'd2) begin
                    r_fg[r_k] <= sat32(acc_sum);
                    r_acc     <= '0;
                    r_t       <= 2'd3;
                end else begin
                    r_acc <= acc_sum;
                    r_t   <= r_t + 2'd1;
                end
            end
            ST_EMIT_G: begin
                r_phase <= 1'b1;
                r_k     <= 2'd0;
                r_t     <= 2'd0;
                r_fc    <= 3'd0;
                r_nd    <= nd_c;
            end
            ST_EMIT_F: begin
                if (out_free) begin
                    r_k  <= 2'd0;
                    r_t  <= 2'd0;
                    r_fc <= r_fc + 3'd1;
                    r_nd <= nd_c;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
